/* rtl/core/auto_range_axis_normalizer_top_macros.svh */
// Assertion macros for the auto-range axis normalizer checker.
// Included by arn_checker.sv; needs nothing else.
`ifndef AUTO_RANGE_AXIS_NORMALIZER_TOP_MACROS_SVH
`define AUTO_RANGE_AXIS_NORMALIZER_TOP_MACROS_SVH

// consequent in the cycle after the antecedent
`define ARN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// consequent in the same cycle
`define ARN_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// checked only while reset is asserted; not disabled by reset
`define ARN_ASSERT_RESET(lbl, clk, rst_n, cons, msg) \
    lbl: assert property (@(posedge clk) !(rst_n) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/arn_pkg.sv */
// Shared types and constants of the auto-range axis normalizer.
// No dependencies; used by arn_track and the top level.
`timescale 1ns / 1ps

package arn_pkg;

    localparam int AXES = 3;

    typedef logic [1:0] t_axis;

    localparam t_axis AXIS_FIRST = 2'd0;
    localparam t_axis AXIS_LAST  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TRACK,
        ST_SPAN,
        ST_DIV,
        ST_DONE
    } t_seq_state;

    typedef struct packed {
        logic  upd;
        logic  wr;
        t_axis axis;
    } t_trk_ctl;

endpackage

/* rtl/core/arn_div.sv */
// Shared restoring divider: one quotient bit per cycle, DUTY_BITS+1 steps.
// Numerator must not exceed denominator. Depends on nothing.
`timescale 1ns / 1ps

module arn_div #(
    parameter int SAMPLE_BITS = 16,
    parameter int DUTY_BITS   = 12
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [SAMPLE_BITS:0] i_num,
    input  logic [SAMPLE_BITS:0] i_den,
    output logic                 o_done,
    output logic [DUTY_BITS:0]   o_quot
);

    localparam int CntBits = $clog2(DUTY_BITS + 1);
    localparam logic [CntBits-1:0] CntLast = CntBits'(DUTY_BITS);

    logic                   r_busy;
    logic                   r_done;
    logic                   r_first;
    logic [CntBits-1:0]     r_cnt;
    logic [SAMPLE_BITS:0]   r_rem;
    logic [SAMPLE_BITS:0]   r_den;
    logic [DUTY_BITS:0]     r_quot;

    logic [SAMPLE_BITS+1:0] w_trial;
    logic [SAMPLE_BITS+1:0] w_diff;
    logic                   w_ge;
    logic [SAMPLE_BITS:0]   n_rem;

    // first step compares the unshifted numerator (quotient MSB)
    always_comb begin
        w_trial = r_first ? {1'b0, r_rem} : {r_rem, 1'b0};
        w_diff  = w_trial - {1'b0, r_den};
        w_ge    = (w_trial >= {1'b0, r_den});
        n_rem   = w_ge ? w_diff[SAMPLE_BITS:0] : w_trial[SAMPLE_BITS:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CntLast) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem   <= i_num;
            r_den   <= i_den;
            r_first <= 1'b1;
            r_quot  <= '0;
        end else if (r_busy) begin
            r_rem   <= n_rem;
            r_first <= 1'b0;
            r_quot  <= {r_quot[DUTY_BITS-1:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

/* rtl/core/arn_track.sv */
// Per-axis range tracker: lowest/highest seen and held duty, three axes.
// Gives span and offset of the selected axis. Uses arn_pkg.
`timescale 1ns / 1ps

module arn_track #(
    parameter int SAMPLE_BITS = 16,
    parameter int DUTY_BITS   = 12
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  arn_pkg::t_trk_ctl                         i_ctl,
    input  logic signed [SAMPLE_BITS-1:0]             i_sample,
    input  logic [DUTY_BITS:0]                        i_duty,
    output logic [SAMPLE_BITS:0]                      o_span,
    output logic [SAMPLE_BITS:0]                      o_off,
    output logic                                      o_nonempty,
    output logic [arn_pkg::AXES-1:0][DUTY_BITS:0]     o_held
);

    localparam logic signed [SAMPLE_BITS-1:0] SmpMax = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SmpMin = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic signed [SAMPLE_BITS-1:0] r_lo [arn_pkg::AXES];
    logic signed [SAMPLE_BITS-1:0] r_hi [arn_pkg::AXES];
    logic [DUTY_BITS:0]            r_held [arn_pkg::AXES];

    logic signed [SAMPLE_BITS-1:0] w_lo;
    logic signed [SAMPLE_BITS-1:0] w_hi;
    logic signed [SAMPLE_BITS:0]   w_span;
    logic signed [SAMPLE_BITS:0]   w_off;

    always_comb begin
        w_lo       = r_lo[i_ctl.axis];
        w_hi       = r_hi[i_ctl.axis];
        w_span     = {w_hi[SAMPLE_BITS-1], w_hi} - {w_lo[SAMPLE_BITS-1], w_lo};
        w_off      = {i_sample[SAMPLE_BITS-1], i_sample} - {w_lo[SAMPLE_BITS-1], w_lo};
        o_nonempty = !w_span[SAMPLE_BITS] && (|w_span);
        o_span     = w_span;
        o_off      = w_off;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < arn_pkg::AXES; a++) begin
                r_lo[a]   <= SmpMax;
                r_hi[a]   <= SmpMin;
                r_held[a] <= '0;
            end
        end else begin
            if (i_ctl.upd) begin
                if (i_sample < w_lo) begin
                    r_lo[i_ctl.axis] <= i_sample;
                end
                if (i_sample > w_hi) begin
                    r_hi[i_ctl.axis] <= i_sample;
                end
            end
            if (i_ctl.wr) begin
                r_held[i_ctl.axis] <= i_duty;
            end
        end
    end

    always_comb begin
        for (int a = 0; a < arn_pkg::AXES; a++) begin
            o_held[a] = r_held[a];
        end
    end

endmodule

/* rtl/core/auto_range_axis_normalizer_top.sv */
// Top level of the auto-range axis normalizer: sequencer, sample and result
// registers. Uses arn_pkg, arn_track, arn_div.
//
//  channel | signals                  | payload
//  --------+--------------------------+--------------------------------------
//  in      | i_valid / o_ready        | i_accel_x, i_accel_y, i_accel_z
//  out     | o_valid / i_ready        | o_duty_x/y/z, o_updated_x/y/z
//
// Per axis: range update (ST_TRACK), span check (ST_SPAN), then the shared
// divider (ST_DIV) when the range is not empty. No new input beat is taken
// until all three axes are through and the result is loaded (ST_DONE).
// o_ready is high only in idle; a held output beat stalls the sequencer at
// its last step. Synchronous active-low reset, no clearing pass.
`timescale 1ns / 1ps

module auto_range_axis_normalizer_top #(
    parameter int SAMPLE_BITS = 16,
    parameter int DUTY_BITS   = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_accel_x,
    input  logic signed [SAMPLE_BITS-1:0] i_accel_y,
    input  logic signed [SAMPLE_BITS-1:0] i_accel_z,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [DUTY_BITS:0]            o_duty_x,
    output logic [DUTY_BITS:0]            o_duty_y,
    output logic [DUTY_BITS:0]            o_duty_z,
    output logic                          o_updated_x,
    output logic                          o_updated_y,
    output logic                          o_updated_z
);

    arn_pkg::t_seq_state r_state;
    arn_pkg::t_seq_state n_state;
    arn_pkg::t_axis      r_axis;

    logic signed [SAMPLE_BITS-1:0] r_smp [arn_pkg::AXES];
    logic [arn_pkg::AXES-1:0]      r_upd;
    logic                          r_out_valid;
    logic [DUTY_BITS:0]            r_out_duty [arn_pkg::AXES];
    logic [arn_pkg::AXES-1:0]      r_out_upd;

    arn_pkg::t_trk_ctl                        w_ctl;
    logic [SAMPLE_BITS:0]                     w_span;
    logic [SAMPLE_BITS:0]                     w_off;
    logic                                     w_nonempty;
    logic [arn_pkg::AXES-1:0][DUTY_BITS:0]    w_held;
    logic                                     w_div_start;
    logic                                     w_div_done;
    logic [DUTY_BITS:0]                       w_quot;
    logic                                     w_accept;
    logic                                     w_out_load;
    logic                                     w_last;

    assign w_accept = i_valid && o_ready;
    assign w_last   = (r_axis == arn_pkg::AXIS_LAST);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            arn_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_state = arn_pkg::ST_TRACK;
                end
            end
            arn_pkg::ST_TRACK: begin
                n_state = arn_pkg::ST_SPAN;
            end
            arn_pkg::ST_SPAN: begin
                if (w_nonempty) begin
                    n_state = arn_pkg::ST_DIV;
                end else if (w_last) begin
                    n_state = arn_pkg::ST_DONE;
                end else begin
                    n_state = arn_pkg::ST_TRACK;
                end
            end
            arn_pkg::ST_DIV: begin
                if (w_div_done) begin
                    n_state = w_last ? arn_pkg::ST_DONE : arn_pkg::ST_TRACK;
                end
            end
            arn_pkg::ST_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_state = arn_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = arn_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ready     = 1'b0;
        w_ctl.upd   = 1'b0;
        w_ctl.wr    = 1'b0;
        w_ctl.axis  = r_axis;
        w_div_start = 1'b0;
        w_out_load  = 1'b0;
        unique case (r_state)
            arn_pkg::ST_IDLE:  o_ready     = 1'b1;
            arn_pkg::ST_TRACK: w_ctl.upd   = 1'b1;
            arn_pkg::ST_SPAN:  w_div_start = w_nonempty;
            arn_pkg::ST_DIV:   w_ctl.wr    = w_div_done;
            arn_pkg::ST_DONE:  w_out_load  = !r_out_valid || i_ready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= arn_pkg::ST_IDLE;
            r_axis      <= arn_pkg::AXIS_FIRST;
            r_upd       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_axis <= arn_pkg::AXIS_FIRST;
            end else if (n_state == arn_pkg::ST_TRACK && r_state != arn_pkg::ST_TRACK) begin
                r_axis <= r_axis + 2'd1;
            end
            if (r_state == arn_pkg::ST_SPAN) begin
                r_upd[r_axis] <= w_nonempty;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_smp[0] <= i_accel_x;
            r_smp[1] <= i_accel_y;
            r_smp[2] <= i_accel_z;
        end
        if (w_out_load) begin
            for (int a = 0; a < arn_pkg::AXES; a++) begin
                r_out_duty[a] <= w_held[a];
            end
            r_out_upd <= r_upd;
        end
    end

    arn_track #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .DUTY_BITS  (DUTY_BITS)
    ) u_track (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_sample   (r_smp[r_axis]),
        .i_duty     (w_quot),
        .o_span     (w_span),
        .o_off      (w_off),
        .o_nonempty (w_nonempty),
        .o_held     (w_held)
    );

    arn_div #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .DUTY_BITS  (DUTY_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_off),
        .i_den   (w_span),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    assign o_valid     = r_out_valid;
    assign o_duty_x    = r_out_duty[0];
    assign o_duty_y    = r_out_duty[1];
    assign o_duty_z    = r_out_duty[2];
    assign o_updated_x = r_out_upd[0];
    assign o_updated_y = r_out_upd[1];
    assign o_updated_z = r_out_upd[2];

endmodule

/* rtl/core/arn_checker.sv */
// Port-level checker for the auto-range axis normalizer, bound to the top.
// Uses auto_range_axis_normalizer_top_macros.svh.
`timescale 1ns / 1ps
`include "auto_range_axis_normalizer_top_macros.svh"

module arn_checker #(
    parameter int SAMPLE_BITS = 16,
    parameter int DUTY_BITS   = 12
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_ready,
    input logic signed [SAMPLE_BITS-1:0] i_accel_x,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic [DUTY_BITS:0]            o_duty_x,
    input logic [DUTY_BITS:0]            o_duty_y,
    input logic [DUTY_BITS:0]            o_duty_z
);

    localparam logic [DUTY_BITS:0] DutyMax = {1'b1, {DUTY_BITS{1'b0}}};

    logic w_in_beat;
    logic w_smp_sign;

    assign w_in_beat  = i_valid && o_ready;
    assign w_smp_sign = i_accel_x[SAMPLE_BITS-1];

    `ARN_ASSERT_RESET(a_rst_out, i_clk, i_rst_n, !o_valid, "output valid after reset")
    `ARN_ASSERT_NEXT(a_busy_after_beat, i_clk, i_rst_n, w_in_beat, !o_ready && !$rose(o_valid), "ready or result right after input beat")
    `ARN_ASSERT_SAME(a_duty_range, i_clk, i_rst_n, o_valid, (o_duty_x <= DutyMax) && (o_duty_y <= DutyMax) && (o_duty_z <= DutyMax), "duty above full scale")
    `ARN_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready && !w_smp_sign, o_valid, "output beat dropped while stalled")

endmodule

bind auto_range_axis_normalizer_top arn_checker #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .DUTY_BITS  (DUTY_BITS)
) u_arn_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_valid   (i_valid),
    .o_ready   (o_ready),
    .i_accel_x (i_accel_x),
    .o_valid   (o_valid),
    .i_ready   (i_ready),
    .o_duty_x  (o_duty_x),
    .o_duty_y  (o_duty_y),
    .o_duty_z  (o_duty_z)
);
